// File: design/ple_pkg.sv
`timescale 1ns / 1ps
// ple_pkg: shared types and constants for the positional list engine.
// No dependencies.
package ple_pkg;

  localparam int CapacityDef = 8;

  localparam int CmdW     = 3;
  localparam int PosW     = 4;
  localparam int ValW     = 32;
  localparam int StatW    = 2;
  localparam int FidxW    = 3;
  localparam int CntOutW  = 4;

  localparam int InDataW  = 40;
  localparam int OutDataW = 16;

  typedef enum logic [CmdW-1:0] {
    CmdAppend     = 3'd0,
    CmdInsert     = 3'd1,
    CmdSearch     = 3'd2,
    CmdRemoveLast = 3'd3,
    CmdRemoveAt   = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StEmpty  = 2'd2,
    StBadPos = 2'd3
  } status_e;

endpackage

// File: design/ple_ram.sv
`timescale 1ns / 1ps
// ple_ram: entry store, one write port and one read port with registered data.
// Depends on nothing.
module ple_ram #(
  parameter int Depth = 8,
  parameter int Width = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/positional_list_engine.sv
`timescale 1ns / 1ps
// positional_list_engine: ordered list of signed words with append, insert,
// search and remove, one request in flight. Uses ple_pkg and ple_ram.
// Each entry moved or compared takes a memory read state and then a write or compare
// state through the single index stepper; insert ends with a write of the new value.
// s_axis_tready is low until done.
// Reset empties the list; entry contents are not cleared.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = CapacityDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [2:0] cmd, [6:3] position, [38:7] value, [39] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] status, [2] found, [5:3] found_index, [9:6] count, [15:10] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [3:0] {
    SIdle, SDecode, SShiftRd, SShiftWr, SInsWr,
    SSrchRd, SSrchCmp, SDnRd, SDnWr, SResult
  } state_e;

  state_e              state_q;
  cmd_e                cmd_q;
  logic [PosW-1:0]     pos_q;
  logic [ValW-1:0]     val_q;
  logic [CntW-1:0]     occ_q;
  logic [CntW-1:0]     idx_q;
  logic [CntW-1:0]     lim_q;
  status_e             res_status_q;
  logic                res_found_q;
  logic [FidxW-1:0]    res_fidx_q;
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  logic [CmpW-1:0] occ_c, pos_c, idx_c, occ_dec_c;
  logic [CntW-1:0] occ_inc, occ_dec, idx_nb;
  logic            full, empty, dir_dn;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [ValW-1:0] ram_wdata, ram_rdata;

  assign occ_inc   = occ_q + 1'b1;
  assign occ_dec   = occ_q - 1'b1;
  assign occ_c     = CmpW'(occ_q);
  assign occ_dec_c = CmpW'(occ_dec);
  assign pos_c     = CmpW'(pos_q);
  assign idx_c     = CmpW'(idx_q);
  assign full      = (occ_q == CntW'(CAPACITY));
  assign empty     = (occ_q == '0);

  // shared index stepper
  assign dir_dn = (state_q == SShiftRd) || (state_q == SShiftWr);
  assign idx_nb = dir_dn ? (idx_q - 1'b1) : (idx_q + 1'b1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[IdxW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_nb[IdxW-1:0];
    case (state_q)
      SDecode: begin
        ram_waddr = occ_q[IdxW-1:0];
        ram_wdata = val_q;
        if (!full && ((cmd_q == CmdAppend) || ((cmd_q == CmdInsert) && (pos_c == occ_c)))) begin
          ram_we = 1'b1;
        end
      end
      SShiftWr, SDnWr: begin
        ram_we = 1'b1;
      end
      SInsWr: begin
        ram_we    = 1'b1;
        ram_wdata = val_q;
      end
      SSrchRd: begin
        ram_raddr = idx_q[IdxW-1:0];
      end
      default: begin
      end
    endcase
  end

  ple_ram #(
    .Depth(CAPACITY),
    .Width(ValW),
    .AddrW(IdxW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      occ_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != SResult)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (s_axis_tvalid) begin
            cmd_q        <= cmd_e'(s_axis_tdata[CmdW-1:0]);
            pos_q        <= s_axis_tdata[CmdW +: PosW];
            val_q        <= s_axis_tdata[CmdW+PosW +: ValW];
            res_status_q <= StOk;
            res_found_q  <= 1'b0;
            res_fidx_q   <= '0;
            state_q      <= SDecode;
          end
        end
        SDecode: begin
          case (cmd_q)
            CmdAppend: begin
              state_q <= SResult;
              if (full) begin
                res_status_q <= StFull;
              end else begin
                occ_q <= occ_inc;
              end
            end
            CmdInsert: begin
              if (full) begin
                res_status_q <= StFull;
                state_q      <= SResult;
              end else if (pos_c > occ_c) begin
                res_status_q <= StBadPos;
                state_q      <= SResult;
              end else if (pos_c == occ_c) begin
                occ_q   <= occ_inc;
                state_q <= SResult;
              end else begin
                idx_q   <= occ_q;
                lim_q   <= pos_c[CntW-1:0];
                state_q <= SShiftRd;
              end
            end
            CmdSearch: begin
              if (!empty) begin
                idx_q   <= '0;
                lim_q   <= occ_q;
                state_q <= SSrchRd;
              end else begin
                state_q <= SResult;
              end
            end
            CmdRemoveLast: begin
              state_q <= SResult;
              if (empty) begin
                res_status_q <= StEmpty;
              end else begin
                occ_q <= occ_dec;
              end
            end
            CmdRemoveAt: begin
              if (empty) begin
                res_status_q <= StEmpty;
                state_q      <= SResult;
              end else if (pos_c >= occ_c) begin
                res_status_q <= StBadPos;
                state_q      <= SResult;
              end else if (pos_c == occ_dec_c) begin
                occ_q   <= occ_dec;
                state_q <= SResult;
              end else begin
                idx_q   <= pos_c[CntW-1:0];
                lim_q   <= occ_dec;
                state_q <= SDnRd;
              end
            end
            default: begin
              res_status_q <= StBadPos;
              state_q      <= SResult;
            end
          endcase
        end
        SShiftRd: begin
          state_q <= SShiftWr;
        end
        SShiftWr: begin
          idx_q   <= idx_nb;
          state_q <= (idx_nb == lim_q) ? SInsWr : SShiftRd;
        end
        SInsWr: begin
          occ_q   <= occ_inc;
          state_q <= SResult;
        end
        SSrchRd: begin
          state_q <= SSrchCmp;
        end
        SSrchCmp: begin
          if (ram_rdata == val_q) begin
            res_found_q <= 1'b1;
            res_fidx_q  <= idx_c[FidxW-1:0];
            state_q     <= SResult;
          end else if (idx_nb == lim_q) begin
            state_q <= SResult;
          end else begin
            idx_q   <= idx_nb;
            state_q <= SSrchRd;
          end
        end
        SDnRd: begin
          state_q <= SDnWr;
        end
        SDnWr: begin
          idx_q <= idx_nb;
          if (idx_nb == lim_q) begin
            occ_q   <= occ_dec;
            state_q <= SResult;
          end else begin
            state_q <= SDnRd;
          end
        end
        SResult: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {(OutDataW - CntOutW - FidxW - 1 - StatW)'(0),
                          occ_c[CntOutW-1:0], res_fidx_q, res_found_q, res_status_q};
            state_q   <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for positional_list_engine. A directed request table,
// then random list traffic, each reply checked against a fixed expected reply or a behavioral copy of the list.
// Depends on ple_pkg and the positional_list_engine RTL.
module testbench
  import ple_pkg::*;
();

  localparam int Cap        = CapacityDef;
  localparam int CycleLimit = 400000;
  localparam int ItemsPerPhase = 483;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [PosW-1:0] position;
    logic [ValW-1:0] value;
  } request_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [FidxW-1:0]   found_index;
    logic [CntOutW-1:0] count;
  } reply_t;

  typedef struct {
    request_t req;
    bit       typed;
    reply_t   rsp;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [ValW-1:0] list_words [Cap];
  int              list_len;
  reply_t          expected_replies [$];
  dir_row_t        dir_rows [$];
  int              mismatches;
  int              cycles;
  int              tx_idle_pct;
  int              rx_idle_pct;
  bit              hold_req;
  bit              hold_seen;
  int              hold_left;
  bit              fill_up;

  positional_list_engine #(
    .CAPACITY(Cap)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Behavioral list: applies one request and returns the reply it causes.
  function automatic reply_t apply_to_list(request_t r);
    reply_t rsp;
    int     i;
    rsp = '{status: StOk, found: 1'b0, found_index: '0, count: '0};
    case (r.cmd)
      CmdAppend: begin
        if (list_len >= Cap) begin
          rsp.status = StFull;
        end else begin
          list_words[list_len] = r.value;
          list_len++;
        end
      end
      CmdInsert: begin
        if (list_len >= Cap) begin
          rsp.status = StFull;
        end else if (int'(r.position) > list_len) begin
          rsp.status = StBadPos;
        end else begin
          for (i = list_len; i > int'(r.position); i--) list_words[i] = list_words[i-1];
          list_words[r.position] = r.value;
          list_len++;
        end
      end
      CmdSearch: begin
        for (i = list_len - 1; i >= 0; i--) begin
          if (list_words[i] == r.value) begin
            rsp.found       = 1'b1;
            rsp.found_index = i[FidxW-1:0];
          end
        end
      end
      CmdRemoveLast: begin
        if (list_len == 0) rsp.status = StEmpty;
        else list_len--;
      end
      CmdRemoveAt: begin
        if (list_len == 0) begin
          rsp.status = StEmpty;
        end else if (int'(r.position) >= list_len) begin
          rsp.status = StBadPos;
        end else begin
          for (i = r.position; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: rsp.status = StBadPos;
    endcase
    rsp.count = list_len[CntOutW-1:0];
    return rsp;
  endfunction

  function automatic void add_row(logic [CmdW-1:0] c, int p, logic [ValW-1:0] v, bit typed,
                                  status_e st = StOk, int cnt = 0);
    dir_row_t row;
    row.req   = '{cmd: c, position: p[PosW-1:0], value: v};
    row.typed = typed;
    row.rsp   = '{status: st, found: 1'b0, found_index: '0, count: cnt[CntOutW-1:0]};
    dir_rows.push_back(row);
  endfunction

  function automatic request_t make_random_request();
    request_t r;
    int       k;
    int       adds;
    if ($urandom_range(29) == 0) fill_up = ~fill_up;
    adds = fill_up ? 24 : 13;
    k = $urandom_range(99);
    if (k < 3) r.cmd = CmdWidthUnknown();
    else if (k < 3 + adds) r.cmd = CmdAppend;
    else if (k < 3 + 2 * adds) r.cmd = CmdInsert;
    else if (k < 3 + 2 * adds + 25) r.cmd = CmdSearch;
    else if (k < 3 + 2 * adds + 25 + (97 - 2 * adds - 25) / 2) r.cmd = CmdRemoveLast;
    else r.cmd = CmdRemoveAt;
    if ($urandom_range(4) == 0) r.position = PosW'($urandom_range(15));
    else r.position = PosW'($urandom_range(list_len));
    if (r.cmd == CmdSearch && list_len > 0 && $urandom_range(9) < 6)
      r.value = list_words[$urandom_range(list_len - 1)];
    else if ($urandom_range(1) == 0)
      r.value = ValW'($urandom_range(3)) - ValW'(2);
    else
      r.value = $urandom;
    return r;
  endfunction

  function automatic logic [CmdW-1:0] CmdWidthUnknown();
    return CmdW'(5 + $urandom_range(2));
  endfunction

  // Entered and left at a falling edge; valid stays high across back-to-back requests.
  task automatic issue_request(request_t r, bit typed, reply_t typed_rsp);
    reply_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r.value, r.position, r.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_to_list(r);
    expected_replies.push_back(typed ? typed_rsp : predicted);
    @(negedge clk_i);
  endtask

  // Receiver side: random stalls plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    hold_seen     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status      = status_e'(m_axis_tdata[1:0]);
      got.found       = m_axis_tdata[2];
      got.found_index = m_axis_tdata[5:3];
      got.count       = m_axis_tdata[9:6];
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply %h", m_axis_tdata);
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.found_index !== want.found_index || got.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d hit=%0d idx=%0d cnt=%0d,",
                      " got st=%0d hit=%0d idx=%0d cnt=%0d"},
                     want.status, want.found, want.found_index, want.count,
                     got.status, got.found, got.found_index, got.count);
        end
      end
    end
  end

  initial begin
    reply_t none;
    int     phase;
    int     n;
    none          = '{status: StOk, found: 1'b0, found_index: '0, count: '0};
    list_len      = 0;
    hold_req      = 1'b0;
    fill_up       = 1'b1;
    tx_idle_pct   = 36;
    rx_idle_pct   = 55;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;

    // empty-list corner cases
    add_row(CmdRemoveLast, 0, 32'h0, 1'b1, StEmpty, 0);
    add_row(CmdRemoveAt, 0, 32'h0, 1'b1, StEmpty, 0);
    add_row(CmdSearch, 0, 32'h0, 1'b1, StOk, 0);
    add_row(CmdInsert, 1, 32'h0, 1'b1, StBadPos, 0);
    add_row(3'd7, 15, 32'hFFFF_FFFF, 1'b1, StBadPos, 0);
    // fill with extreme values
    add_row(CmdAppend, 0, 32'h8000_0000, 1'b1, StOk, 1);
    add_row(CmdAppend, 0, 32'h7FFF_FFFF, 1'b1, StOk, 2);
    add_row(CmdInsert, 0, 32'h0, 1'b1, StOk, 3);
    add_row(CmdInsert, 3, 32'hFFFF_FFFF, 1'b1, StOk, 4);
    add_row(CmdInsert, 2, 32'd5, 1'b0);
    add_row(CmdSearch, 0, 32'h7FFF_FFFF, 1'b0);
    add_row(CmdSearch, 0, 32'hFFFF_FFFF, 1'b0);
    add_row(CmdSearch, 0, 32'd12345, 1'b0);
    add_row(CmdAppend, 0, 32'd5, 1'b0);
    add_row(CmdSearch, 0, 32'd5, 1'b0);
    add_row(CmdAppend, 0, 32'd2, 1'b0);
    add_row(CmdAppend, 0, 32'd3, 1'b1, StOk, 8);
    // full-list corner cases, then removals and unknown commands
    add_row(CmdAppend, 0, 32'd4, 1'b1, StFull, 8);
    add_row(CmdInsert, 0, 32'd4, 1'b1, StFull, 8);
    add_row(CmdInsert, 15, 32'd4, 1'b1, StFull, 8);
    add_row(CmdRemoveAt, 8, 32'h0, 1'b1, StBadPos, 8);
    add_row(CmdRemoveAt, 15, 32'h0, 1'b1, StBadPos, 8);
    add_row(CmdSearch, 0, 32'd3, 1'b0);
    add_row(CmdRemoveAt, 0, 32'h0, 1'b1, StOk, 7);
    add_row(CmdRemoveLast, 0, 32'h0, 1'b1, StOk, 6);
    add_row(3'd5, 0, 32'h0, 1'b1, StBadPos, 6);
    add_row(3'd6, 0, 32'h0, 1'b1, StBadPos, 6);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 55 : 0;
      rx_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 36 : 0;
      for (n = 0; n < ItemsPerPhase; n++) begin
        if (phase == 0 && n == 150) hold_req = 1'b1;
        issue_request(make_random_request(), 1'b0, none);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: positional_list_engine.f
design/ple_pkg.sv
design/ple_ram.sv
design/positional_list_engine.sv
tb/testbench.sv
